[rtl/core/assert_macros.svh]
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or implication property, checked on every rising edge out of reset.
`define CD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deque assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define CD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

[rtl/core/cdq_pkg.sv]
// Shared types, constants and index helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAPE_W     = IDX_W + 1;
    localparam int S_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RES_W      = 3 + 2 * DATA_WIDTH;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CAPE_W-1:0]     cap_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RESP
    } state_t;

    // Memory request from the controller
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        data_t wdata;
        idx_t  raddr;
    } mem_req_t;

    // One result beat
    typedef struct packed {
        data_t rear_value;
        data_t front_value;
        logic  is_full;
        logic  is_empty;
        logic  accepted;
    } result_t;

    // Controller handshake toward the output stage
    typedef struct packed {
        logic    res_valid;
        result_t res;
    } res_stream_t;

    // Clamp a written capacity into 1..DEPTH
    function automatic cap_t eff_cap(logic [CAP_W-1:0] c);
        if (c == '0) begin
            return cap_t'(1);
        end
        if (int'(c) > DEPTH) begin
            return cap_t'(DEPTH);
        end
        return cap_t'(c);
    endfunction

    function automatic idx_t step_up(idx_t i, cap_t cap);
        cap_t nxt;
        nxt = {1'b0, i} + cap_t'(1);
        return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
    endfunction

    function automatic idx_t step_down(idx_t i, cap_t cap);
        cap_t lim;
        lim = cap - cap_t'(1);
        return (i == '0 || {1'b0, i} >= cap) ? lim[IDX_W-1:0] : i - idx_t'(1);
    endfunction

endpackage

[rtl/core/cdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/cdq_ctrl.sv]
// Deque controller: index bookkeeping, cached end values and ring access sequencing.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  op_t              in_op,
    input  data_t            in_data,
    input  logic             out_free,
    input  data_t            rd_data,
    output mem_req_t         mem_req,
    output res_stream_t      res_out
);

    state_t state_reg, state_next;
    cap_t   cap_reg;
    idx_t   front_idx_reg, front_idx_next;
    idx_t   rear_idx_reg, rear_idx_next;
    logic   empty_reg, empty_next;
    logic   ok_reg, ok_next;
    data_t  front_val_reg, front_val_next;
    data_t  rear_val_reg, rear_val_next;
    logic   load_front_reg, load_front_next;
    logic   need_read;
    logic   accept;
    logic   full_now;

    assign accept   = in_valid && in_ready;
    assign full_now = !empty_reg && (step_up(rear_idx_reg, cap_reg) == front_idx_reg);

    // operation datapath: index moves, ring writes and read requests
    always_comb begin
        front_idx_next  = front_idx_reg;
        rear_idx_next   = rear_idx_reg;
        empty_next      = empty_reg;
        ok_next         = ok_reg;
        front_val_next  = front_val_reg;
        rear_val_next   = rear_val_reg;
        load_front_next = load_front_reg;
        need_read       = 1'b0;
        mem_req.we      = 1'b0;
        mem_req.waddr   = '0;
        mem_req.wdata   = in_data;
        mem_req.raddr   = '0;
        if (accept) begin
            ok_next = 1'b0;
            case (in_op) inside
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (!full_now) begin
                        ok_next    = 1'b1;
                        mem_req.we = 1'b1;
                        if (empty_reg) begin
                            front_idx_next = '0;
                            rear_idx_next  = '0;
                            empty_next     = 1'b0;
                            front_val_next = in_data;
                            rear_val_next  = in_data;
                        end else if (in_op == OP_PUSH_FRONT) begin
                            front_idx_next = step_down(front_idx_reg, cap_reg);
                            mem_req.waddr  = front_idx_next;
                            front_val_next = in_data;
                        end else begin
                            rear_idx_next = step_up(rear_idx_reg, cap_reg);
                            mem_req.waddr = rear_idx_next;
                            rear_val_next = in_data;
                        end
                    end
                end
                default: begin
                    if (!empty_reg) begin
                        ok_next = 1'b1;
                        if (front_idx_reg == rear_idx_reg) begin
                            front_idx_next = '0;
                            rear_idx_next  = '0;
                            empty_next     = 1'b1;
                        end else if (in_op == OP_POP_FRONT) begin
                            front_idx_next  = step_up(front_idx_reg, cap_reg);
                            mem_req.raddr   = front_idx_next;
                            need_read       = 1'b1;
                            load_front_next = 1'b1;
                        end else begin
                            rear_idx_next   = step_down(rear_idx_reg, cap_reg);
                            mem_req.raddr   = rear_idx_next;
                            need_read       = 1'b1;
                            load_front_next = 1'b0;
                        end
                    end
                end
            endcase
        end
        // refill the cached end value from the ring
        if (state_reg == ST_LOAD) begin
            if (load_front_reg) begin
                front_val_next = rd_data;
            end else begin
                rear_val_next = rd_data;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_read ? ST_LOAD : ST_RESP;
                end
            end
            ST_LOAD: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready                  = (state_reg == ST_IDLE);
        res_out.res_valid         = (state_reg == ST_RESP);
        res_out.res.accepted      = ok_reg;
        res_out.res.is_empty      = empty_reg;
        res_out.res.is_full       = full_now;
        res_out.res.front_value   = empty_reg ? '1 : front_val_reg;
        res_out.res.rear_value    = empty_reg ? '1 : rear_val_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= eff_cap(CAP_W'(16));
            front_idx_reg <= '0;
            rear_idx_reg  <= '0;
            empty_reg     <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg       <= eff_cap(cfg_wr_data);
                front_idx_reg <= '0;
                rear_idx_reg  <= '0;
                empty_reg     <= 1'b1;
            end else begin
                front_idx_reg <= front_idx_next;
                rear_idx_reg  <= rear_idx_next;
                empty_reg     <= empty_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ok_reg         <= ok_next;
        front_val_reg  <= front_val_next;
        rear_val_reg   <= rear_val_next;
        load_front_reg <= load_front_next;
    end

endmodule

[rtl/core/circular_deque_unit.sv]
// Top level of the circular deque: controller, ring RAM and result register.
// A push or refused op goes from idle straight to the response state; a pop that must
// fetch the new end value from the ring RAM passes through a load state first.
// The controller takes one item at a time and takes no new one until the result
// register is free to accept its result; the output register frees it.
// Reset (aresetn low, synchronous): deque empty, indices zero, capacity 16;
// ring contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque_unit import cdq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CAP_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [DATA_WIDTH-1:0] data_value
    input  logic [1:0]           s_tuser,   // [1:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // from bit 0: accepted, is_empty, is_full, front_value, rear_value, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    mem_req_t    mem_req;
    res_stream_t res_stream;
    data_t       rd_data;
    logic        out_free;
    logic        m_tvalid_reg;
    result_t     res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    cdq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (op_t'(s_tuser)),
        .in_data     (s_tdata[DATA_WIDTH-1:0]),
        .out_free    (out_free),
        .rd_data     (rd_data),
        .mem_req     (mem_req),
        .res_out     (res_stream)
    );

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_stream.res_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_stream.res_valid && out_free) begin
            res_reg <= res_stream.res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(res_reg);

    // checks
    `CD_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CD_ASSERT(a_empty_reads_ones, aclk, aresetn,
        !(m_tvalid_reg && res_reg.is_empty) ||
        (res_reg.front_value == '1 && res_reg.rear_value == '1))
    `CD_ASSERT(a_not_empty_and_full, aclk, aresetn,
        !(m_tvalid_reg && res_reg.is_empty && res_reg.is_full))

endmodule
